// ===== rtl/repeating_timer_table_top_defines.svh =====
// Assertion macros for the repeating timer table.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef REPEATING_TIMER_TABLE_TOP_DEFINES_SVH
`define REPEATING_TIMER_TABLE_TOP_DEFINES_SVH

// Implication checked one cycle at a time, masked during reset.
`define RTT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked against the following cycle.
`define RTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rtt_pkg.sv =====
// Shared types and constants for the repeating timer table.
// No dependencies.
`default_nettype none
package rtt_pkg;
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0, CMD_ADD = 3'd1, CMD_REMOVE = 3'd2,
    CMD_RESET = 3'd3, CMD_REMOVE_ALL = 3'd4, CMD_QUERY = 3'd5
  } cmd_e_t;

  typedef enum logic [2:0] {
    KIND_FIRED = 3'd0, KIND_ADDED = 3'd1, KIND_REJECTED = 3'd2,
    KIND_MATCH = 3'd3, KIND_DONE = 3'd4
  } kind_e_t;

  // Contents of one timer slot.
  typedef struct packed {
    logic        valid;
    logic [31:0] start;
    logic [31:0] delay;
    logic [31:0] repeats;
  } slot_t;

  // Captured request.
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic [3:0]  slot;
    logic [31:0] delay_ms;
    logic [31:0] repeat_count;
    logic [31:0] window_ms;
  } req_t;

  // Result of evaluating the head slot.
  typedef struct packed {
    logic        emit;
    logic [2:0]  kind;
    logic [31:0] time_left;
    logic        placed;
  } head_res_t;
endpackage
`default_nettype wire

// ===== rtl/rtt_cell.sv =====
// One slot of the rotating timer ring: holds a slot and takes its neighbor's on shift.
// Depends on rtt_pkg.
`default_nettype none
module rtt_cell (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           shift,
  input  rtt_pkg::slot_t d_in,
  output rtt_pkg::slot_t q
);
  import rtt_pkg::*;

  logic        valid_r;
  logic [31:0] start_r, delay_r, repeats_r;

  // The valid flag is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= d_in.valid;
    end
  end

  // Timer fields carry no reset.
  always_ff @(posedge clk) begin
    if (shift) begin
      start_r   <= d_in.start;
      delay_r   <= d_in.delay;
      repeats_r <= d_in.repeats;
    end
  end

  assign q = '{valid: valid_r, start: start_r, delay: delay_r, repeats: repeats_r};
endmodule
`default_nettype wire

// ===== rtl/rtt_head.sv =====
// Applies the current request to the slot at the head of the ring.
// Depends on rtt_pkg.
`default_nettype none
module rtt_head (
  input  rtt_pkg::slot_t     head,
  input  rtt_pkg::req_t      req,
  input  wire [rtt_pkg::IDX_W-1:0] idx,
  input  wire                placed,
  input  wire [31:0]         min_interval,
  output rtt_pkg::slot_t     upd,
  output rtt_pkg::head_res_t res
);
  import rtt_pkg::*;

  logic [31:0] due, left, idx32;
  logic        fire, hit;

  assign due   = head.start + head.delay;
  assign left  = due - req.now_ms;
  assign fire  = head.valid && (req.now_ms >= due);
  assign idx32 = 32'(idx);
  assign hit   = (32'(req.slot) == idx32);

  always_comb begin
    upd = head;
    res = '{emit: 1'b0, kind: KIND_DONE, time_left: 32'd0, placed: placed};
    case (cmd_e_t'(req.command))
      CMD_TICK: begin
        if (fire) begin
          res.emit = 1'b1;
          res.kind = KIND_FIRED;
          if (head.repeats == 32'd1) begin
            upd.valid = 1'b0;
          end else begin
            if (head.repeats != 32'd0) upd.repeats = head.repeats - 32'd1;
            upd.start = req.now_ms;
          end
        end
      end
      CMD_ADD: begin
        if (!placed && !head.valid && req.delay_ms >= min_interval) begin
          upd = '{valid: 1'b1, start: req.now_ms, delay: req.delay_ms,
                  repeats: req.repeat_count};
          res.emit   = 1'b1;
          res.kind   = KIND_ADDED;
          res.placed = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (hit) upd.valid = 1'b0;
      end
      CMD_RESET: begin
        if (hit && head.valid) upd.start = req.now_ms;
      end
      CMD_REMOVE_ALL: begin
        upd.valid = 1'b0;
      end
      CMD_QUERY: begin
        if (head.valid && (req.window_ms == 32'd0 || left <= req.window_ms)) begin
          res.emit      = 1'b1;
          res.kind      = KIND_MATCH;
          res.time_left = left;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/repeating_timer_table_top.sv =====
// Repeating timer table: a ring of slot cells rotated past one evaluation head.
// Depends on rtt_pkg, rtt_cell, rtt_head and repeating_timer_table_top_defines.svh.
// A request is taken in the idle state, then the ring rotates through every slot in the scan state
// and the done state follows (a rejected add issues the reject first); no new request is taken until done.
// Results are registered after their slot is evaluated; output stalls hold the scan.
// Synchronous active-low reset clears all valid flags and sets min_interval to 50.
`default_nettype none
module repeating_timer_table_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [2:0]   in_command,
  input  wire [31:0]  in_now_ms,
  input  wire [3:0]   in_slot,
  input  wire [31:0]  in_delay_ms,
  input  wire [31:0]  in_repeat_count,
  input  wire [31:0]  in_window_ms,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_slot_id,
  output logic [31:0] out_time_left,
  output logic        out_last,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [2:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtt_pkg::*;
`include "repeating_timer_table_top_defines.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  state_t          state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic            placed_r, placed_nxt;
  req_t            req_r, req_nxt;
  logic [31:0]     min_interval_r, min_interval_nxt;
  logic            out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [2:0]      out_kind_r, out_kind_nxt;
  logic [3:0]      out_slot_r, out_slot_nxt;
  logic [31:0]     out_left_r, out_left_nxt, idx32;

  slot_t           ring_q [SLOTS];
  slot_t           head_upd;
  head_res_t       head_res;
  logic            adv, shift, in_acc;

  // Output register may be refilled when empty or being taken.
  assign adv    = !out_valid_r || !out_stall;
  assign shift  = (state_r == ST_SCAN) && adv;
  assign in_acc = in_valid && (state_r == ST_IDLE);
  assign idx32  = 32'(idx_r);

  // Ring of slot cells; the evaluated head re-enters at the tail.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    slot_t d_in;
    if (g == SLOTS - 1) begin : g_tail
      assign d_in = head_upd;
    end else begin : g_mid
      assign d_in = ring_q[g+1];
    end
    rtt_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift), .d_in(d_in), .q(ring_q[g]));
  end

  rtt_head u_head (
    .head(ring_q[0]), .req(req_r), .idx(idx_r), .placed(placed_r),
    .min_interval(min_interval_r), .upd(head_upd), .res(head_res)
  );

  // Sequencer, output register and configuration next values.
  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    placed_nxt       = placed_r;
    req_nxt          = req_r;
    min_interval_nxt = min_interval_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_kind_nxt     = out_kind_r;
    out_slot_nxt     = out_slot_r;
    out_left_nxt     = out_left_r;
    out_last_nxt     = out_last_r;
    if (psel && penable && pwrite && !paddr[2]) min_interval_nxt = pwdata;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt    = '{command: in_command, now_ms: in_now_ms, slot: in_slot,
                         delay_ms: in_delay_ms, repeat_count: in_repeat_count,
                         window_ms: in_window_ms};
          idx_nxt    = '0;
          placed_nxt = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          placed_nxt = head_res.placed;
          if (head_res.emit) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = head_res.kind;
            out_slot_nxt  = idx32[3:0];
            out_left_nxt  = head_res.time_left;
            out_last_nxt  = 1'b0;
          end
          if (idx_r == IDX_W'(SLOTS - 1)) begin
            idx_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_DONE: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = 4'd0;
          out_left_nxt  = 32'd0;
          if (cmd_e_t'(req_r.command) == CMD_ADD && !placed_r) begin
            out_kind_nxt = KIND_REJECTED;
            out_last_nxt = 1'b0;
            placed_nxt   = 1'b1;
          end else begin
            out_kind_nxt = KIND_DONE;
            out_last_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idx_r          <= '0;
      placed_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      min_interval_r <= 32'd50;
    end else begin
      state_r        <= state_nxt;
      idx_r          <= idx_nxt;
      placed_r       <= placed_nxt;
      out_valid_r    <= out_valid_nxt;
      min_interval_r <= min_interval_nxt;
    end
    req_r      <= req_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_left_r <= out_left_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_slot_id   = out_slot_r;
  assign out_time_left = out_left_r;
  assign out_last      = out_last_r;
  assign prdata        = paddr[2] ? 32'd0 : min_interval_r;
  assign pready        = 1'b1;

  // An accepted request always starts a scan.
  `RTT_ASSERT_NEXT(a_acc_scan, in_valid && !in_stall, state_r == ST_SCAN, "request did not start scan")
  // The ring is back in slot order whenever requests are taken.
  `RTT_ASSERT_IMP(a_ring_home, state_r != ST_SCAN, idx_r == '0, "ring left rotated")
  // Only the done item carries last.
  `RTT_ASSERT_IMP(a_last_done, out_valid && out_last, out_kind == KIND_DONE, "last on non-done item")
endmodule
`default_nettype wire

// ===== verif/repeating_timer_table_top_tb.sv =====
// Self-checking testbench for the repeating timer table.
// Depends on rtt_pkg and repeating_timer_table_top; predicts every result in the bench itself.
`default_nettype none
module repeating_timer_table_top_tb;
  import rtt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] ADDR_MIN_INTERVAL = 3'd0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic [31:0] in_now_ms = '0;
  logic [3:0] in_slot = '0;
  logic [31:0] in_delay_ms = '0;
  logic [31:0] in_repeat_count = '0;
  logic [31:0] in_window_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_kind;
  logic [3:0] out_slot_id;
  logic [31:0] out_time_left;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  repeating_timer_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_now_ms(in_now_ms), .in_slot(in_slot), .in_delay_ms(in_delay_ms),
    .in_repeat_count(in_repeat_count), .in_window_ms(in_window_ms),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_slot_id(out_slot_id), .out_time_left(out_time_left), .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot_id;
    logic [31:0] time_left;
    logic last;
  } timer_event_t;

  // One row of the directed table; typed rows carry their first expected result.
  typedef struct packed {
    req_t req;
    logic typed;
    timer_event_t typed_ev;
  } row_t;

  // Shadow copy of the timer table and its register.
  logic [31:0] shadow_min_interval;
  logic shadow_valid [SLOTS];
  logic [31:0] shadow_start [SLOTS];
  logic [31:0] shadow_delay [SLOTS];
  logic [31:0] shadow_repeats [SLOTS];

  timer_event_t pending_events[$];
  row_t directed_rows[$];
  int fail_count = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  function automatic timer_event_t make_event(kind_e_t k, int id, logic [31:0] left,
                                              logic lst);
    timer_event_t ev;
    ev.kind = k;
    ev.slot_id = id[3:0];
    ev.time_left = left;
    ev.last = lst;
    return ev;
  endfunction

  // Append one expected result to the tail of the queue.
  function automatic void queue_event(timer_event_t ev);
    pending_events = {pending_events, ev};
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(req_t r, logic typed, timer_event_t ev);
    row_t row;
    row.req = r;
    row.typed = typed;
    row.typed_ev = ev;
    directed_rows = {directed_rows, row};
  endfunction

  // Apply one request to the shadow table and queue the events it causes.
  task automatic predict_events(req_t r);
    logic [31:0] due;
    logic [31:0] left;
    logic placed;
    placed = 1'b0;
    case (r.command)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!shadow_valid[i]) continue;
          due = shadow_start[i] + shadow_delay[i];
          if (r.now_ms < due) continue;
          queue_event(make_event(KIND_FIRED, i, '0, 1'b0));
          if (shadow_repeats[i] == 32'd1) begin
            shadow_valid[i] = 1'b0;
          end else begin
            if (shadow_repeats[i] != 0) shadow_repeats[i] = shadow_repeats[i] - 1;
            shadow_start[i] = r.now_ms;
          end
        end
      end
      CMD_ADD: begin
        if (r.delay_ms >= shadow_min_interval) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!placed && !shadow_valid[i]) begin
              shadow_valid[i] = 1'b1;
              shadow_start[i] = r.now_ms;
              shadow_delay[i] = r.delay_ms;
              shadow_repeats[i] = r.repeat_count;
              queue_event(make_event(KIND_ADDED, i, '0, 1'b0));
              placed = 1'b1;
            end
          end
        end
        if (!placed) queue_event(make_event(KIND_REJECTED, 0, '0, 1'b0));
      end
      CMD_REMOVE: begin
        if (r.slot < SLOTS) shadow_valid[r.slot] = 1'b0;
      end
      CMD_RESET: begin
        if (r.slot < SLOTS && shadow_valid[r.slot]) shadow_start[r.slot] = r.now_ms;
      end
      CMD_REMOVE_ALL: begin
        for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;
      end
      CMD_QUERY: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!shadow_valid[i]) continue;
          left = shadow_start[i] + shadow_delay[i] - r.now_ms;
          if (r.window_ms == 0 || left <= r.window_ms)
            queue_event(make_event(KIND_MATCH, i, left, 1'b0));
        end
      end
      default: ;
    endcase
    queue_event(make_event(KIND_DONE, 0, '0, 1'b1));
  endtask

  // Check each accepted result against the oldest expected event.
  always @(posedge clk) begin
    timer_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result kind=%0d slot=%0d left=%0d last=%0b", $time,
                 out_kind, out_slot_id, out_time_left, out_last);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        if (want.kind !== out_kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_kind);
          fail_count++;
        end
        if (want.slot_id !== out_slot_id) begin
          $display("%0t: slot_id expected %0d actual %0d", $time, want.slot_id, out_slot_id);
          fail_count++;
        end
        if (want.time_left !== out_time_left) begin
          $display("%0t: time_left expected %0d actual %0d", $time, want.time_left,
                   out_time_left);
          fail_count++;
        end
        if (want.last !== out_last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // Receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
  end

  // Watchdog on cycles with no accepted request, result or register access.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Issue one request and wait for it to be accepted. A typed row replaces the
  // first predicted result with the value written in the table.
  task automatic send_request(req_t r, logic typed = 1'b0, timer_event_t typed_ev = '0);
    int base;
    while ($urandom_range(99, 0) < sender_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_command <= r.command;
    in_now_ms <= r.now_ms;
    in_slot <= r.slot;
    in_delay_ms <= r.delay_ms;
    in_repeat_count <= r.repeat_count;
    in_window_ms <= r.window_ms;
    do @(posedge clk); while (in_stall);
    base = pending_events.size();
    predict_events(r);
    if (typed) pending_events[base] = typed_ev;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write min_interval through the register port once the table is idle.
  task automatic write_min_interval(logic [31:0] value);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_MIN_INTERVAL;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_min_interval = value;
  endtask

  function automatic req_t make_req(cmd_e_t c, logic [31:0] now, logic [3:0] s,
                                    logic [31:0] d, logic [31:0] reps, logic [31:0] w);
    req_t r;
    r.command = c;
    r.now_ms = now;
    r.slot = s;
    r.delay_ms = d;
    r.repeat_count = reps;
    r.window_ms = w;
    return r;
  endfunction

  logic [31:0] clock_ms;

  initial begin
    req_t r;
    int cmd_pick;
    shadow_min_interval = 32'd50;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_start[i] = '0;
      shadow_delay[i] = '0;
      shadow_repeats[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset: empty query, reject <50, accept 50, timer ops, unknown codes.
    add_row(make_req(CMD_QUERY, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0), 1'b1,
            make_event(KIND_DONE, 0, '0, 1'b1));
    add_row(make_req(CMD_ADD, 32'd0, 4'd0, 32'd49, 32'd1, 32'd0), 1'b1,
            make_event(KIND_REJECTED, 0, '0, 1'b0));
    add_row(make_req(CMD_ADD, 32'd0, 4'd0, 32'd50, 32'd1, 32'd0), 1'b1,
            make_event(KIND_ADDED, 0, '0, 1'b0));
    add_row(make_req(CMD_ADD, 32'hFFFF_FFF0, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0),
            1'b1, make_event(KIND_ADDED, 1, '0, 1'b0));
    add_row(make_req(CMD_ADD, 32'd10, 4'd0, 32'd100, 32'd0, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_ADD, 32'd10, 4'd0, 32'd60, 32'd2, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_QUERY, 32'd20, 4'd0, 32'd0, 32'd0, 32'd40), 1'b0, '0);
    add_row(make_req(CMD_QUERY, 32'd20, 4'd0, 32'd0, 32'd0, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(make_req(CMD_TICK, 32'd70, 4'd0, 32'd0, 32'd0, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_TICK, 32'd200, 4'd0, 32'd0, 32'd0, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_RESET, 32'd300, 4'd2, 32'd0, 32'd0, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_RESET, 32'd300, 4'd15, 32'd0, 32'd0, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_REMOVE, 32'd300, 4'd15, 32'd0, 32'd0, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_REMOVE, 32'd300, 4'd2, 32'd0, 32'd0, 32'd0), 1'b0, '0);
    add_row(make_req(cmd_e_t'(3'd6), 32'd0, 4'd0, 32'd0, 32'd0, 32'd0), 1'b1,
            make_event(KIND_DONE, 0, '0, 1'b1));
    add_row(make_req(cmd_e_t'(3'd7), 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
            make_event(KIND_DONE, 0, '0, 1'b1));
    for (int i = 0; i < 4; i++)
      add_row(make_req(CMD_ADD, 32'd400, 4'd0, 32'd1000, 32'd3, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_TICK, 32'hFFFF_FFFF, 4'd0, 32'd0, 32'd0, 32'd0), 1'b0, '0);
    add_row(make_req(CMD_REMOVE_ALL, 32'd0, 4'd0, 32'd0, 32'd0, 32'd0), 1'b0, '0);
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].typed_ev);

    // Fill the table past full with the minimum interval at zero.
    write_min_interval(32'd0);
    for (int i = 0; i <= SLOTS; i++)
      send_request(make_req(CMD_ADD, 32'd5, 4'd0, 32'd0, 32'd1, 32'd0));
    send_request(make_req(CMD_TICK, 32'd5, 4'd0, 32'd0, 32'd0, 32'd0));
    write_min_interval(32'hFFFF_FFFF);
    send_request(make_req(CMD_ADD, 32'd5, 4'd0, 32'hFFFF_FFFE, 32'd1, 32'd0));
    send_request(make_req(CMD_ADD, 32'd5, 4'd0, 32'hFFFF_FFFF, 32'd1, 32'd0));

    // Random phases: mostly add/tick/query traffic on an advancing clock.
    clock_ms = $urandom;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 84; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 84; end
        3: begin sender_idle_pct = 13; receiver_stall_pct = 13; end
        default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
      endcase
      write_min_interval(phase == 4 ? 32'd0 : $urandom_range(100, 0));
      for (int n = 0; n < 32; n++) begin
        clock_ms = clock_ms + $urandom_range(120, 0);
        cmd_pick = $urandom_range(99, 0);
        r = make_req(CMD_TICK, clock_ms, 4'($urandom), $urandom_range(300, 0),
                     $urandom_range(4, 0), $urandom_range(300, 0));
        if (cmd_pick < 35) r.command = CMD_ADD;
        else if (cmd_pick < 65) r.command = CMD_TICK;
        else if (cmd_pick < 78) r.command = CMD_QUERY;
        else if (cmd_pick < 86) r.command = CMD_REMOVE;
        else if (cmd_pick < 93) r.command = CMD_RESET;
        else if (cmd_pick < 96) r.command = CMD_REMOVE_ALL;
        else begin
          // Raw noise over every field.
          r = make_req(cmd_e_t'($urandom_range(7, 0)), $urandom, 4'($urandom), $urandom,
                       $urandom, $urandom);
        end
        if ($urandom_range(9, 0) == 0) r.window_ms = 0;
        if ($urandom_range(19, 0) == 0) r.delay_ms = $urandom;
        send_request(r);
      end
    end

    // Drain outstanding results, then settle.
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/rtt_pkg.sv
rtl/rtt_cell.sv
rtl/rtt_head.sv
rtl/repeating_timer_table_top.sv
verif/repeating_timer_table_top_tb.sv
